### hdl/neso_pkg.sv
// ----------------------------------------------------------------------------
// neso_pkg
// shared types, register codes and constant tables of the observer
// ----------------------------------------------------------------------------
package neso_pkg;

  localparam logic signed [31:0] DIST_LIMIT = 32'sd3276800;
  localparam logic signed [63:0] SAT_MAX    = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN    = -64'sd2147483648;
  localparam logic [16:0]        Q_ONE      = 17'h10000;

  typedef enum logic [2:0] {
    REG_GAIN_POS     = 3'd0,
    REG_GAIN_VEL     = 3'd1,
    REG_GAIN_DIST    = 3'd2,
    REG_STEP_TIME    = 3'd3,
    REG_POWER_FIRST  = 3'd4,
    REG_POWER_SECOND = 3'd5,
    REG_LINEAR_ZONE  = 3'd6,
    REG_SMOOTHING    = 3'd7
  } neso_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_LOAD, ST_START, ST_FAL,
    ST_P1, ST_B1, ST_P2, ST_N1,
    ST_P3, ST_B2, ST_P4, ST_N2,
    ST_P5, ST_B3, ST_P6, ST_N3,
    ST_P7, ST_F1, ST_P8, ST_F2,
    ST_OUT
  } neso_state_e;

  typedef enum logic [3:0] {
    FS_IDLE, FS_NORM, FS_LOG, FS_POW, FS_EXP,
    FS_SHIFT, FS_LO, FS_HI, FS_SAT, FS_DONE
  } neso_fal_state_e;

  typedef struct packed {
    logic [15:0] alpha1;
    logic [15:0] alpha2;
    logic [31:0] delta;
  } neso_fal_cfg_t;

  // digit-by-digit integer square root, elaboration only
  function automatic logic [31:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  // factors 2^(2^-k), k = 1..16, in Q1.30
  function automatic logic [15:0][30:0] exp_factor_table();
    logic [15:0][30:0] t;
    logic [63:0]       c;
    c = 64'h8000_0000;
    for (int k = 0; k < 16; k++) begin
      c    = {32'b0, isqrt64(c << 30)};
      t[k] = c[30:0];
    end
    return t;
  endfunction

  localparam logic [15:0][30:0] EXP_FACTOR = exp_factor_table();

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/neso_ram.sv
// ----------------------------------------------------------------------------
// neso_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module neso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/neso_fal.sv
// ----------------------------------------------------------------------------
// neso_fal
// iterative fal unit: log2 by squaring, exp2 by factor products, one multiplier
// ----------------------------------------------------------------------------
module neso_fal
  import neso_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] err_i,
  input  neso_fal_cfg_t      cfg_i,
  output logic               done_o,
  output logic signed [31:0] fal1_o,
  output logic signed [31:0] fal2_o
);

  neso_fal_state_e state_q, state_d;
  logic [3:0]  step_q;
  logic        sel_q;

  logic [31:0] mag_q;
  logic        neg_q;
  logic        pow_q;
  logic [31:0] m_q;
  logic [4:0]  cnt_q;
  logic [15:0] frac_q;
  logic signed [21:0] y_q;
  logic [30:0] mant_q;
  logic [63:0] r_q;
  logic [63:0] acc_q;
  logic signed [31:0] f1_q, f2_q;

  logic [31:0] mag_w;
  logic [4:0]  sh;
  logic [31:0] top_mask;
  logic        top_zero;
  logic [32:0] sq_t;
  logic [15:0] alpha;
  logic signed [16:0] pow_exp;
  logic signed [20:0] log_w;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [5:0]  exp_int;
  logic signed [6:0]  shamt;
  logic [6:0]  rsh;
  logic [63:0] r_shift;
  logic [63:0] val;
  logic [30:0] mag_sat;
  logic signed [31:0] f_w;

  assign mag_w    = err_i[31] ? 32'(-err_i) : err_i;
  assign sh       = 5'd16 >> step_q[2:0];
  assign top_mask = ~(32'hFFFF_FFFF >> sh);
  assign top_zero = (m_q & top_mask) == 32'b0;
  assign sq_t     = prod[63:31];
  assign alpha    = sel_q ? cfg_i.alpha2 : cfg_i.alpha1;
  // linear branch uses alpha - 1.0
  assign pow_exp  = {~pow_q, alpha};
  assign log_w    = {5'd15 - cnt_q, frac_q};
  assign exp_int  = y_q[21:16];
  assign shamt    = 7'(exp_int) - 7'sd14;
  assign rsh      = 7'(-shamt);
  assign r_shift  = shamt[6] ? (64'(mant_q) >> rsh) : (64'(mant_q) << shamt[5:0]);
  assign val      = pow_q ? r_q : {16'b0, acc_q[63:16]};
  assign mag_sat  = (val > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : val[30:0];
  assign f_w      = neg_q ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      FS_LOG: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      FS_POW: begin
        mul_a = 33'(pow_exp);
        mul_b = 33'(log_w);
      end
      FS_EXP: begin
        mul_a = {2'b0, mant_q};
        mul_b = {2'b0, EXP_FACTOR[step_q]};
      end
      FS_LO: begin
        mul_a = {1'b0, mag_q};
        mul_b = {1'b0, r_q[31:0]};
      end
      FS_HI: begin
        mul_a = {1'b0, mag_q};
        mul_b = {1'b0, r_q[63:32]};
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE: begin
        if (start_i) begin
          state_d = (err_i == 32'sd0) ? FS_DONE : FS_NORM;
        end
      end
      FS_NORM:  if (step_q == 4'd4) state_d = FS_LOG;
      FS_LOG:   if (step_q == 4'd15) state_d = FS_POW;
      FS_POW:   state_d = FS_EXP;
      FS_EXP:   if (step_q == 4'd15) state_d = FS_SHIFT;
      FS_SHIFT: state_d = pow_q ? FS_SAT : FS_LO;
      FS_LO:    state_d = FS_HI;
      FS_HI:    state_d = FS_SAT;
      FS_SAT:   state_d = sel_q ? FS_DONE : FS_POW;
      FS_DONE:  state_d = FS_IDLE;
      default:  state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      step_q  <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_d != state_q) ? 4'd0 : step_q + 4'd1;
      if (state_q == FS_IDLE) begin
        sel_q <= 1'b0;
      end else if (state_q == FS_SAT) begin
        sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      FS_IDLE: begin
        if (start_i) begin
          mag_q  <= mag_w;
          neg_q  <= err_i[31];
          pow_q  <= mag_w > cfg_i.delta;
          m_q    <= (mag_w > cfg_i.delta) ? mag_w : cfg_i.delta;
          cnt_q  <= '0;
          frac_q <= '0;
          f1_q   <= '0;
          f2_q   <= '0;
        end
      end
      FS_NORM: begin
        if (top_zero) begin
          m_q   <= m_q << sh;
          cnt_q <= cnt_q + sh;
        end
      end
      FS_LOG: begin
        if (sq_t[32]) begin
          m_q             <= sq_t[32:1];
          frac_q[~step_q] <= 1'b1;
        end else begin
          m_q <= sq_t[31:0];
        end
      end
      FS_POW: begin
        y_q    <= prod[37:16];
        mant_q <= 31'h4000_0000;
      end
      FS_EXP: begin
        if (y_q[~step_q]) begin
          mant_q <= prod[60:30];
        end
      end
      FS_SHIFT: r_q <= r_shift;
      FS_LO:    acc_q <= prod[63:0];
      FS_HI:    acc_q <= acc_q + {prod[31:0], 32'b0};
      FS_SAT: begin
        if (sel_q) begin
          f2_q <= f_w;
        end else begin
          f1_q <= f_w;
        end
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == FS_DONE);
  assign fal1_o = f1_q;
  assign fal2_o = f2_q;

endmodule

### hdl/nonlinear_extended_state_observer_unit.sv
// ----------------------------------------------------------------------------
// nonlinear_extended_state_observer_unit
// third-order nonlinear extended state observer, one axis per word
// work: the fal unit (5 normalize, 16 log2 squarings, 2 x 16 exp2 products on
//   one multiplier) takes most of each word; a zero error skips its steps and
//   an axis out of range goes straight to the result
// throughput: one word at a time; the block goes idle as the result enters the
//   output register and takes the next word in the cycle after
// reset: config registers to defaults, all axis states read as zero
// ----------------------------------------------------------------------------
module nonlinear_extended_state_observer_unit
  import neso_pkg::*;
#(
  parameter int NUM_AXES = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         axis_i,
  input  logic signed [31:0] measurement_i,
  input  logic signed [31:0] drive_term_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         axis_out_o,
  output logic signed [22:0] disturbance_o
);

  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  // config registers
  logic [31:0] gain_pos_q, gain_vel_q, gain_dist_q, ts_q, zone_q;
  logic [15:0] pow1_q, pow2_q, smooth_q;

  neso_state_e state_q, state_d;

  // word in flight
  logic [1:0]         axis_q;
  logic signed [31:0] meas_q, drive_q;
  logic               in_range_q;
  logic [AW+1:0]      axis_ext;
  logic [AW-1:0]      addr;

  // loaded state and intermediate results
  logic signed [31:0] z1_q, z2_q, z3_q, zf_q, e_q;
  logic signed [31:0] b_q, n1_q, n2_q, n3_q, zfn_q;
  logic signed [65:0] prod_q;
  logic signed [50:0] acc_q;

  // per-axis valid bits, a never-written axis reads as zero
  logic [NUM_AXES-1:0] vld_q;

  logic [127:0]       rdata, rd;
  logic               mem_we;
  logic               in_accept, out_free;
  logic               out_valid_q;
  logic [1:0]         axis_out_q;
  logic signed [22:0] dist_q;

  logic               fal_start, fal_done;
  logic signed [31:0] fal1, fal2;
  neso_fal_cfg_t      fal_cfg;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [63:0] wide;
  logic signed [31:0] wide_sat;
  logic signed [31:0] wide_clamp;
  logic [16:0]        w_keep;
  logic signed [51:0] zf_sum;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign axis_ext  = (AW + 2)'(axis_q);
  assign addr      = axis_ext[AW-1:0];

  // ---------------------------------------------------------------------------
  // config writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_pos_q  <= 32'd6553600;
      gain_vel_q  <= 32'd19660800;
      gain_dist_q <= 32'd65536000;
      ts_q        <= 32'd4294967;
      pow1_q      <= 16'd52429;
      pow2_q      <= 16'd52429;
      zone_q      <= 32'd9830;
      smooth_q    <= 16'd6554;
    end else if (cfg_we_i) begin
      case (neso_reg_e'(cfg_idx_i))
        REG_GAIN_POS:     gain_pos_q  <= cfg_data_i;
        REG_GAIN_VEL:     gain_vel_q  <= cfg_data_i;
        REG_GAIN_DIST:    gain_dist_q <= cfg_data_i;
        REG_STEP_TIME:    ts_q        <= cfg_data_i;
        REG_POWER_FIRST:  pow1_q      <= cfg_data_i[15:0];
        REG_POWER_SECOND: pow2_q      <= cfg_data_i[15:0];
        REG_LINEAR_ZONE:  zone_q      <= cfg_data_i;
        REG_SMOOTHING:    smooth_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // state memory: one entry per axis, {zf, z3, z2, z1}
  // ---------------------------------------------------------------------------
  assign mem_we = (state_q == ST_OUT) && out_free && in_range_q;

  neso_ram #(
    .WIDTH (128),
    .DEPTH (NUM_AXES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr),
    .wdata_i ({zfn_q, n3_q, n2_q, n1_q}),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  assign rd = vld_q[addr] ? rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[addr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // fal unit, evaluates both gains of the error
  // ---------------------------------------------------------------------------
  assign fal_start = (state_q == ST_START);
  assign fal_cfg   = '{alpha1: pow1_q, alpha2: pow2_q, delta: zone_q};

  neso_fal u_fal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fal_start),
    .err_i   (e_q),
    .cfg_i   (fal_cfg),
    .done_o  (fal_done),
    .fal1_o  (fal1),
    .fal2_o  (fal2)
  );

  // ---------------------------------------------------------------------------
  // shared multiplier for the euler updates and the low-pass filter
  // ---------------------------------------------------------------------------
  assign w_keep = Q_ONE - {1'b0, smooth_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_P1: begin
        mul_a = {1'b0, gain_pos_q};
        mul_b = 33'(e_q);
      end
      ST_P2, ST_P4, ST_P6: begin
        mul_a = 33'(b_q);
        mul_b = {1'b0, ts_q};
      end
      ST_P3: begin
        mul_a = {1'b0, gain_vel_q};
        mul_b = 33'(fal1);
      end
      ST_P5: begin
        mul_a = {1'b0, gain_dist_q};
        mul_b = 33'(fal2);
      end
      ST_P7: begin
        mul_a = {16'b0, w_keep};
        mul_b = 33'(zf_q);
      end
      ST_P8: begin
        mul_a = {17'b0, smooth_q};
        mul_b = 33'(n3_q);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // error from the loaded state, then add and saturate (clamp for z3) after each registered product
  always_comb begin
    wide = '0;
    case (state_q)
      ST_LOAD: wide = 64'($signed(rd[31:0])) - 64'(meas_q);
      ST_B1:   wide = 64'(z2_q) - 64'($signed(prod_q[65:16]));
      ST_N1:   wide = 64'(z1_q) + 64'($signed(prod_q[65:32]));
      ST_B2:   wide = 64'(z3_q) - 64'($signed(prod_q[65:16])) + 64'(drive_q);
      ST_N2:   wide = 64'(z2_q) + 64'($signed(prod_q[65:32]));
      ST_B3:   wide = -64'($signed(prod_q[65:16]));
      ST_N3:   wide = 64'(z3_q) + 64'($signed(prod_q[65:32]));
      default: ;
    endcase
  end

  assign wide_sat = sat32(wide);
  // disturbance estimate held within +-50.0
  assign wide_clamp = (wide > 64'(DIST_LIMIT))  ? DIST_LIMIT :
                      (wide < -64'(DIST_LIMIT)) ? -DIST_LIMIT : wide[31:0];
  assign zf_sum = 52'(acc_q) + 52'($signed(prod_q[50:0]));

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (32'(axis_i) < NUM_AXES) ? ST_READ : ST_OUT;
        end
      end
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_START;
      ST_START: state_d = ST_FAL;
      ST_FAL:   if (fal_done) state_d = ST_P1;
      ST_P1:    state_d = ST_B1;
      ST_B1:    state_d = ST_P2;
      ST_P2:    state_d = ST_N1;
      ST_N1:    state_d = ST_P3;
      ST_P3:    state_d = ST_B2;
      ST_B2:    state_d = ST_P4;
      ST_P4:    state_d = ST_N2;
      ST_N2:    state_d = ST_P5;
      ST_P5:    state_d = ST_B3;
      ST_B3:    state_d = ST_P6;
      ST_P6:    state_d = ST_N3;
      ST_N3:    state_d = ST_P7;
      ST_P7:    state_d = ST_F1;
      ST_F1:    state_d = ST_P8;
      ST_P8:    state_d = ST_F2;
      ST_F2:    state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      axis_q     <= axis_i;
      meas_q     <= measurement_i;
      drive_q    <= drive_term_i;
      in_range_q <= (32'(axis_i) < NUM_AXES);
    end
    case (state_q)
      ST_LOAD: begin
        z1_q <= rd[31:0];
        z2_q <= rd[63:32];
        z3_q <= rd[95:64];
        zf_q <= rd[127:96];
        e_q  <= wide_sat;
      end
      ST_P1, ST_P2, ST_P3, ST_P4,
      ST_P5, ST_P6, ST_P7, ST_P8: prod_q <= prod;
      ST_B1, ST_B2, ST_B3: b_q  <= wide_sat;
      ST_N1: n1_q  <= wide_sat;
      ST_N2: n2_q  <= wide_sat;
      ST_N3: n3_q  <= wide_clamp;
      ST_F1: acc_q <= prod_q[50:0];
      ST_F2: zfn_q <= zf_sum[47:16];
      default: ;
    endcase
  end

  // output register, lets the next word in while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      axis_out_q <= axis_q;
      dist_q     <= in_range_q ? zfn_q[22:0] : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign axis_out_o    = axis_out_q;
  assign disturbance_o = dist_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_fal_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fal_done |-> (state_q == ST_FAL))
    else $error("fal unit finished outside its wait state");

  a_dist_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (dist_q <= 23'sd3276800) && (dist_q >= -23'sd3276800))
    else $error("disturbance result outside +-50");

  a_accept_path : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_READ) || (state_q == ST_OUT))
    else $error("accepted word did not start a read or a direct result");

endmodule

### tb/nonlinear_extended_state_observer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonlinear_extended_state_observer_unit_tb
// self-checking bench: a queue-fed driver offers axis words with random gaps,
// a bit-exact observer predictor tracks z1, z2, z3 and the filtered
// disturbance per axis, and a monitor compares each result word in order;
// config registers change between phases while the block is idle
// ----------------------------------------------------------------------------
module nonlinear_extended_state_observer_unit_tb
  import neso_pkg::*;
();

  localparam int  AXES       = 3;
  localparam int  DRAIN_WAIT = 150;    // beyond the worst-case latency
  localparam real HALF_CLK   = 2.0;

  typedef struct {
    logic [1:0]         axis;
    logic signed [31:0] meas;
    logic signed [31:0] drive;
  } axis_word_t;

  typedef struct {
    logic [1:0]         axis;
    logic signed [22:0] est;
  } dist_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         axis_i = '0;
  logic signed [31:0] measurement_i = '0;
  logic signed [31:0] drive_term_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         axis_out_o;
  logic signed [22:0] disturbance_o;

  // stimulus and expectation stores
  axis_word_t pending_words[$];
  dist_word_t expected_dist[$];
  int         mismatches = 0;
  int         words_taken = 0;
  bit         quiet = 1'b0;        // no idling on either side while set

  // shadow of the config registers and of the per-axis observer state
  logic [31:0] cfg_shadow[8];
  longint      obs_z1[AXES];
  longint      obs_z2[AXES];
  longint      obs_z3[AXES];
  longint      obs_zf[AXES];

  nonlinear_extended_state_observer_unit #(
    .NUM_AXES(AXES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .axis_i        (axis_i),
    .measurement_i (measurement_i),
    .drive_term_i  (drive_term_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .axis_out_o    (axis_out_o),
    .disturbance_o (disturbance_o)
  );

  always #(HALF_CLK) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // observer predictor
  // ---------------------------------------------------------------------------

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // truncating integer square root
  function automatic logic [63:0] root_floor(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v && b != 0) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 of a positive Q16.16 raw value, signed Q16 result
  function automatic longint log2_fix(input logic [63:0] x);
    int          p;
    logic [63:0] m;
    longint      frac;
    p = 0;
    frac = 0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = i;
    end
    m = (p <= 31) ? (x << (31 - p)) : (x >> (p - 31));
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac = frac | (64'sd1 << (16 - i));
      end
    end
    return longint'(p - 16) * 65536 + frac;
  endfunction

  // 2^y for signed Q16 y, Q16.16 raw result
  function automatic logic [63:0] exp2_fix(input longint y);
    longint      n;
    longint      f;
    longint      s;
    logic [63:0] c;
    logic [63:0] mant;
    n = y >>> 16;
    f = y - n * 65536;
    c = 64'd1 << 31;
    mant = 64'd1 << 30;
    for (int k = 1; k <= 16; k++) begin
      c = root_floor(c << 30);
      if ((f >> (16 - k)) & 1) mant = (mant * c) >> 30;
    end
    s = n - 14;
    if (s > 30) s = 30;
    if (s >= 0) begin
      return mant << s;
    end
    if (-s >= 63) begin
      return 64'd0;
    end
    return mant >> (-s);
  endfunction

  // sign(e)*|e|^a outside the linear zone, e / d^(1-a) inside
  function automatic longint fal_gain(input longint e, input longint alpha,
                                      input longint delta);
    logic [63:0] mag;
    logic [63:0] r;
    logic [63:0] k;
    if (e == 0) begin
      return 0;
    end
    mag = (e < 0) ? -e : e;
    if (mag > delta) begin
      r = exp2_fix((alpha * log2_fix(mag)) >>> 16);
    end else begin
      k = exp2_fix(((alpha - 65536) * log2_fix(delta)) >>> 16);
      r = (mag * k) >> 16;
    end
    if (r > 64'd2147483647) r = 64'd2147483647;
    return (e < 0) ? -longint'(r) : longint'(r);
  endfunction

  // one observer step on the accepted word, returns the expected result
  function automatic dist_word_t observer_step(input axis_word_t w);
    dist_word_t res;
    longint     ts;
    longint     wt;
    longint     e;
    longint     f1;
    longint     f2;
    longint     b;
    longint     n1;
    longint     n2;
    longint     n3;
    longint     zf;
    int         a;
    res.axis = w.axis;
    res.est = '0;
    if (w.axis >= AXES) begin
      return res;
    end
    a  = w.axis;
    ts = longint'(cfg_shadow[REG_STEP_TIME]);
    wt = longint'(cfg_shadow[REG_SMOOTHING]);
    e  = clip32(obs_z1[a] - longint'(w.meas));
    f1 = fal_gain(e, longint'(cfg_shadow[REG_POWER_FIRST]),
                  longint'(cfg_shadow[REG_LINEAR_ZONE]));
    f2 = fal_gain(e, longint'(cfg_shadow[REG_POWER_SECOND]),
                  longint'(cfg_shadow[REG_LINEAR_ZONE]));
    b  = clip32(obs_z2[a] - ((longint'(cfg_shadow[REG_GAIN_POS]) * e) >>> 16));
    n1 = clip32(obs_z1[a] + ((b * ts) >>> 32));
    b  = clip32(obs_z3[a] - ((longint'(cfg_shadow[REG_GAIN_VEL]) * f1) >>> 16)
                + longint'(w.drive));
    n2 = clip32(obs_z2[a] + ((b * ts) >>> 32));
    b  = clip32(-((longint'(cfg_shadow[REG_GAIN_DIST]) * f2) >>> 16));
    n3 = obs_z3[a] + ((b * ts) >>> 32);
    if (n3 > longint'(DIST_LIMIT)) n3 = longint'(DIST_LIMIT);
    if (n3 < -longint'(DIST_LIMIT)) n3 = -longint'(DIST_LIMIT);
    zf = ((65536 - wt) * obs_zf[a] + wt * n3) >>> 16;
    obs_z1[a] = n1;
    obs_z2[a] = n2;
    obs_z3[a] = n3;
    obs_zf[a] = zf;
    res.est = zf[22:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver, monitors and receiver
  // ---------------------------------------------------------------------------

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, 60);
  endfunction

  int send_gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        axis_word_t w;
        w = pending_words.pop_front();
        axis_i <= w.axis;
        measurement_i <= w.meas;
        drive_term_i <= w.drive;
        in_valid_i <= 1'b1;
        send_gap <= idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // predict on every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      axis_word_t w;
      w.axis = axis_i;
      w.meas = measurement_i;
      w.drive = drive_term_i;
      expected_dist.push_back(observer_step(w));
      words_taken <= words_taken + 1;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_dist.size() == 0) begin
        report_mismatch($sformatf("unexpected word axis %0d estimate %0d",
                                  axis_out_o, disturbance_o));
      end else begin
        dist_word_t x;
        x = expected_dist.pop_front();
        if (axis_out_o !== x.axis) begin
          report_mismatch($sformatf("axis_out %0d, want %0d", axis_out_o, x.axis));
        end
        if (disturbance_o !== x.est) begin
          report_mismatch($sformatf("axis %0d disturbance %0d, want %0d",
                                    x.axis, disturbance_o, x.est));
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold so the block backs up
  int stall_run = 0;
  int long_hold = 0;
  bit hold_armed = 1'b1;

  always @(posedge clk_i) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall_i <= 1'b1;
    end else if (hold_armed && words_taken >= 300) begin
      hold_armed <= 1'b0;
      long_hold <= 500;
      out_stall_i <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall_i <= 1'b1;
    end else begin
      int n;
      n = idle_len();
      stall_run <= (n > 0) ? n - 1 : 0;
      out_stall_i <= (n > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic write_reg(input neso_reg_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    cfg_shadow[idx] = (idx == REG_POWER_FIRST || idx == REG_POWER_SECOND ||
                       idx == REG_SMOOTHING) ? {16'b0, data[15:0]} : data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_word(input logic [1:0] axis, input logic [31:0] meas,
                          input logic [31:0] drive);
    axis_word_t w;
    w.axis = axis;
    w.meas = meas;
    w.drive = drive;
    @(negedge clk_i);
    pending_words.push_back(w);
  endtask

  // wait until every word was sent and answered, then let the block settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_words.size() > 0 || in_valid_i || expected_dist.size() > 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      2: return $signed($urandom_range(0, 1 << 15)) - (1 << 14);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic random_words(input int count);
    logic [1:0] axis;
    for (int i = 0; i < count; i++) begin
      axis = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      add_word(axis, rand_value(), rand_value());
    end
  endtask

  task automatic random_config();
    write_reg(REG_GAIN_POS,     $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 24));
    write_reg(REG_GAIN_VEL,     $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 26));
    write_reg(REG_GAIN_DIST,    $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 27));
    write_reg(REG_STEP_TIME,    $urandom_range(1, 32'hFFFF_FFFF));
    write_reg(REG_POWER_FIRST,  $urandom_range(1, 65535));
    write_reg(REG_POWER_SECOND, $urandom_range(1, 65535));
    write_reg(REG_LINEAR_ZONE,  $urandom_range(0, 1) ? $urandom_range(1, 1 << 18)
                                                     : $urandom_range(1, 32'hFFFF_FFFF));
    write_reg(REG_SMOOTHING,    $urandom_range(0, 65535));
  endtask

  initial begin
    cfg_shadow[REG_GAIN_POS]     = 32'd6553600;
    cfg_shadow[REG_GAIN_VEL]     = 32'd19660800;
    cfg_shadow[REG_GAIN_DIST]    = 32'd65536000;
    cfg_shadow[REG_STEP_TIME]    = 32'd4294967;
    cfg_shadow[REG_POWER_FIRST]  = 32'd52429;
    cfg_shadow[REG_POWER_SECOND] = 32'd52429;
    cfg_shadow[REG_LINEAR_ZONE]  = 32'd9830;
    cfg_shadow[REG_SMOOTHING]    = 32'd6554;
    for (int a = 0; a < AXES; a++) begin
      obs_z1[a] = 0;
      obs_z2[a] = 0;
      obs_z3[a] = 0;
      obs_zf[a] = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words under the reset config
    add_word(2'd0, 32'd0, 32'd0);                  // zero error
    add_word(2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);  // largest error, max drive
    add_word(2'd0, 32'h8000_0000, 32'h8000_0000);  // saturating error, min drive
    add_word(2'd1, 32'd100, 32'd0);                // inside the linear zone
    add_word(2'd1, -32'sd100, 32'd0);
    add_word(2'd1, 32'd9830, 32'd65536);           // right at the zone edge
    add_word(2'd2, 32'd196608, -32'sd65536);
    add_word(2'd2, -32'sd196608, 32'd65536);
    add_word(2'd3, 32'd12345, 32'd999);            // axis out of range
    add_word(2'd3, 32'h8000_0000, 32'h7FFF_FFFF);
    add_word(2'd2, 32'd0, 32'd0);
    random_words(40);
    wait_drained();

    // extremes: largest gains and step, tightest zone
    write_reg(REG_GAIN_POS, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_VEL, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_DIST, 32'hFFFF_FFFF);
    write_reg(REG_STEP_TIME, 32'hFFFF_FFFF);
    write_reg(REG_POWER_FIRST, 32'd65535);
    write_reg(REG_POWER_SECOND, 32'd1);
    write_reg(REG_LINEAR_ZONE, 32'd1);
    write_reg(REG_SMOOTHING, 32'd65535);
    random_words(60);
    wait_drained();

    // extremes: zero gains, smallest step, widest zone
    write_reg(REG_GAIN_POS, 32'd0);
    write_reg(REG_GAIN_VEL, 32'd0);
    write_reg(REG_GAIN_DIST, 32'd0);
    write_reg(REG_STEP_TIME, 32'd1);
    write_reg(REG_POWER_FIRST, 32'd1);
    write_reg(REG_POWER_SECOND, 32'd65535);
    write_reg(REG_LINEAR_ZONE, 32'hFFFF_FFFF);
    write_reg(REG_SMOOTHING, 32'd0);
    random_words(60);
    wait_drained();

    // back to the usual tuning, with a burst and no idling at all
    write_reg(REG_GAIN_POS, 32'd6553600);
    write_reg(REG_GAIN_VEL, 32'd19660800);
    write_reg(REG_GAIN_DIST, 32'd65536000);
    write_reg(REG_STEP_TIME, 32'd4294967);
    write_reg(REG_POWER_FIRST, 32'd52429);
    write_reg(REG_POWER_SECOND, 32'd52429);
    write_reg(REG_LINEAR_ZONE, 32'd9830);
    write_reg(REG_SMOOTHING, 32'd6554);
    @(negedge clk_i);
    quiet = 1'b1;
    random_words(60);
    wait_drained();
    quiet = 1'b0;

    // random tunings; the long output hold falls in here
    for (int p = 0; p < 6; p++) begin
      random_config();
      random_words(80);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(8ms);
    $display("Verification failed");
    $finish;
  end

endmodule

### nonlinear_extended_state_observer_unit.f
hdl/neso_pkg.sv
hdl/neso_ram.sv
hdl/neso_fal.sv
hdl/nonlinear_extended_state_observer_unit.sv
tb/nonlinear_extended_state_observer_unit_tb.sv
